// ----- hw/rtl/mvfs_pkg.sv -----
// Package for the matrix-vector frontier step core.
// Holds widths, register indexes, request codes and the sequencer state type.
// No dependencies.
package mvfs_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = $clog2(MAX_NODES + 1);
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = COUNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_NODE = 1'd1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_MATRIX = 1'b1;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET  = COUNT_W'(MAX_NODES);
    localparam logic [NODE_W-1:0]  TARGET_NODE_RESET = NODE_W'(MAX_NODES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } state_t;

endpackage

// ----- hw/rtl/matrix_vector_frontier_step_core.sv -----
// Matrix-vector frontier step core: vector store memory, multiply and accumulate.
// Depends on mvfs_pkg.
//
// A load transfer (req_type 0) writes one vector element into a single-port
// synchronous memory. A matrix transfer (req_type 1) runs as a sequence: the
// accept cycle issues the read of the vector element for the current column,
// ST_MUL multiplies the returned element by the matrix value (low 32 bits
// kept), and ST_ACC adds the product into the running sum. That read,
// multiply, accumulate sequence on the one memory port means that a matrix
// element waits until the last one has finished. At the end of each row a result
// goes to an output register; the next item is accepted while it waits, and only
// a second row end stalls until the first result is taken. The vector store has
// no reset: every column in use must be loaded before the matrix is streamed.
// Configuration writes are taken at any time but are meant for idle periods.
module matrix_vector_frontier_step_core (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [mvfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvfs_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [mvfs_pkg::NODE_W-1:0]         vector_index,
    input  logic signed [mvfs_pkg::DATA_W-1:0]  value,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mvfs_pkg::NODE_W-1:0]         row_index,
    output logic signed [mvfs_pkg::DATA_W-1:0]  path_count,
    output logic                                last
);

    mvfs_pkg::state_t state_reg, state_next;

    logic [mvfs_pkg::COUNT_W-1:0] node_count_reg;
    logic [mvfs_pkg::NODE_W-1:0]  target_node_reg;

    logic [mvfs_pkg::DATA_W-1:0]  vector_store [mvfs_pkg::MAX_NODES];
    logic [mvfs_pkg::DATA_W-1:0]  rdata_reg;

    logic [mvfs_pkg::DATA_W-1:0]  value_reg;
    logic [mvfs_pkg::DATA_W-1:0]  product_reg;
    logic [mvfs_pkg::DATA_W-1:0]  sum_reg;
    logic [mvfs_pkg::NODE_W-1:0]  col_reg;
    logic [mvfs_pkg::NODE_W-1:0]  row_reg;

    logic                         out_valid_reg;
    logic [mvfs_pkg::NODE_W-1:0]  row_index_reg;
    logic [mvfs_pkg::DATA_W-1:0]  path_count_reg;
    logic                         last_reg;

    logic                         in_xfer;
    logic                         mem_we;
    logic                         mem_re;
    logic                         advance;

    logic [mvfs_pkg::COUNT_W-1:0] n_active;
    logic [mvfs_pkg::COUNT_W-1:0] col_plus;
    logic [mvfs_pkg::COUNT_W-1:0] row_plus;
    logic                         row_done;
    logic                         final_row;
    logic [mvfs_pkg::DATA_W-1:0]  sum_total;
    logic [2*mvfs_pkg::DATA_W-1:0] product_full;

    // Clamp the node count into 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
            n_active = mvfs_pkg::COUNT_W'(1);
        else if (node_count_reg > mvfs_pkg::COUNT_W'(mvfs_pkg::MAX_NODES))
            n_active = mvfs_pkg::COUNT_W'(mvfs_pkg::MAX_NODES);
        else
            n_active = node_count_reg;
    end

    assign col_plus     = {1'b0, col_reg} + mvfs_pkg::COUNT_W'(1);
    assign row_plus     = {1'b0, row_reg} + mvfs_pkg::COUNT_W'(1);
    assign row_done     = (col_plus >= n_active);
    assign final_row    = (row_plus >= n_active);
    assign sum_total    = sum_reg + product_reg;
    assign product_full = value_reg * rdata_reg;
    assign in_xfer      = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= mvfs_pkg::NODE_COUNT_RESET;
            target_node_reg <= mvfs_pkg::TARGET_NODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mvfs_pkg::CFG_NODE_COUNT:  node_count_reg  <= cfg_data;
                mvfs_pkg::CFG_TARGET_NODE: target_node_reg <= cfg_data[mvfs_pkg::NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mvfs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and control
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        advance    = 1'b0;
        unique case (state_reg)
            mvfs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == mvfs_pkg::REQ_MATRIX)
                    begin
                        mem_re     = 1'b1;
                        state_next = mvfs_pkg::ST_MUL;
                    end
                    else
                        mem_we = 1'b1;
                end
            end
            mvfs_pkg::ST_MUL:
                state_next = mvfs_pkg::ST_ACC;
            mvfs_pkg::ST_ACC:
            begin
                // Hold while a row result has nowhere to go
                if (!(row_done && out_valid_reg && !out_ready))
                begin
                    advance    = 1'b1;
                    state_next = mvfs_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mvfs_pkg::ST_IDLE;
        endcase
    end

    // Vector store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            vector_store[vector_index] <= value;
        if (mem_re)
            rdata_reg <= vector_store[col_reg];
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && (req_type == mvfs_pkg::REQ_MATRIX))
            value_reg <= value;
        if (state_reg == mvfs_pkg::ST_MUL)
            product_reg <= product_full[mvfs_pkg::DATA_W-1:0];
        if (advance && row_done)
        begin
            row_index_reg  <= row_reg;
            path_count_reg <= (row_reg == target_node_reg) ? '0 : sum_total;
            last_reg       <= final_row;
        end
    end

    // Sum, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (row_done)
                begin
                    sum_reg <= '0;
                    col_reg <= '0;
                    row_reg <= final_row ? '0 : row_plus[mvfs_pkg::NODE_W-1:0];
                end
                else
                begin
                    sum_reg <= sum_total;
                    col_reg <= col_plus[mvfs_pkg::NODE_W-1:0];
                end
            end

            if (advance && row_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_index  = row_index_reg;
    assign path_count = path_count_reg;
    assign last       = last_reg;

endmodule
